/* rtl/tlp_pkg.sv */
// shared types and constants for the tensor layout permute block
package tlp_pkg;

  localparam int IndexBits    = 24;
  localparam int DestW        = 24;
  localparam int ValueW       = 32;
  localparam int CfgDataW     = 13;
  localparam int CfgIdxW      = 3;
  localparam int TotalW       = 43;
  localparam int SettleCycles = 3;
  localparam int SettleW      = $clog2(SettleCycles + 1);

  typedef enum logic [1:0] {
    MODE_NCHW_NHWC = 2'd0,
    MODE_NHWC_NCHW = 2'd1,
    MODE_OIKK_IOKK = 2'd2
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MODE    = 3'd0,
    REG_OUTER   = 3'd1,
    REG_CHANNEL = 3'd2,
    REG_HEIGHT  = 3'd3,
    REG_WIDTH   = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [6:0]  outer_count;
    logic [12:0] channel_count;
    logic [10:0] height;
    logic [10:0] width;
  } cfg_t;

  typedef struct packed {
    logic             ok;
    logic [DestW-1:0] s_outer;
    logic [DestW-1:0] s_chan;
    logic [DestW-1:0] s_row;
    logic [DestW-1:0] s_col;
  } stride_t;

endpackage

/* rtl/tlp_stride.sv */
// stride and settings check pipeline: three registered multiply stages
module tlp_stride (
  input  logic            clk_i,
  input  tlp_pkg::cfg_t   cfg_i,
  output tlp_pkg::stride_t stride_o
);
  import tlp_pkg::*;

  localparam logic [TotalW-1:0] MaxTotal = {{(TotalW-1){1'b0}}, 1'b1} << IndexBits;

  logic [10:0] w_eff;
  logic        range_ok;

  logic [21:0] hw_q;
  logic [23:0] wc_q;
  logic [21:0] hh_q;
  logic        ok1_q;

  logic [34:0] hwc_q;
  logic [28:0] ohh_q;
  logic        ok2_q;

  logic [TotalW-1:0] total;
  stride_t           stride_d;
  stride_t           stride_q;

  assign w_eff = (cfg_i.mode == MODE_OIKK_IOKK) ? cfg_i.height : cfg_i.width;

  assign range_ok = (cfg_i.mode == MODE_NCHW_NHWC || cfg_i.mode == MODE_NHWC_NCHW ||
                     cfg_i.mode == MODE_OIKK_IOKK) &&
                    cfg_i.outer_count != 7'd0 && cfg_i.outer_count <= 7'd64 &&
                    cfg_i.channel_count != 13'd0 && cfg_i.channel_count <= 13'd4096 &&
                    cfg_i.height != 11'd0 && cfg_i.height <= 11'd1024 &&
                    w_eff != 11'd0 && w_eff <= 11'd1024;

  assign total = TotalW'(cfg_i.outer_count) * TotalW'(hwc_q);

  always_comb begin
    stride_d    = '0;
    stride_d.ok = ok2_q && (total <= MaxTotal);
    case (cfg_i.mode)
      MODE_NCHW_NHWC: begin
        stride_d.s_outer = DestW'(hwc_q);
        stride_d.s_chan  = DestW'(1);
        stride_d.s_row   = DestW'(wc_q);
        stride_d.s_col   = DestW'(cfg_i.channel_count);
      end
      MODE_NHWC_NCHW: begin
        stride_d.s_outer = DestW'(hwc_q);
        stride_d.s_chan  = DestW'(hw_q);
        stride_d.s_row   = DestW'(w_eff);
        stride_d.s_col   = DestW'(1);
      end
      MODE_OIKK_IOKK: begin
        stride_d.s_outer = DestW'(hh_q);
        stride_d.s_chan  = DestW'(ohh_q);
        stride_d.s_row   = DestW'(cfg_i.height);
        stride_d.s_col   = DestW'(1);
      end
      default: begin
        stride_d.ok = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    hw_q     <= 22'(cfg_i.height) * 22'(w_eff);
    wc_q     <= 24'(w_eff) * 24'(cfg_i.channel_count);
    hh_q     <= 22'(cfg_i.height) * 22'(cfg_i.height);
    ok1_q    <= range_ok;
    hwc_q    <= 35'(hw_q) * 35'(cfg_i.channel_count);
    ohh_q    <= 29'(cfg_i.outer_count) * 29'(hh_q);
    ok2_q    <= ok1_q;
    stride_q <= stride_d;
  end

  assign stride_o = stride_q;

endmodule

/* rtl/tensor_layout_permute.sv */
// top level: streaming tensor layout permute with destination index generation
//
// Elements enter in source order, one transfer per cycle, and each is held in the
// output register with its destination index from the cycle after it is taken; a new
// element is taken every cycle while the output side keeps up and no settle is pending.
// The destination index is the sum of four per-axis terms that step by strides, so no
// multiply sits in the element path. The strides and the settings check come from a
// three-stage registered multiplier pipeline: after reset and after every write to one
// of the five registers the input is held off while it settles; such a write also restarts the position counters.
module tensor_layout_permute (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tlp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tlp_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [31:0]                   s_axis_tdata,   // elem_value
  input  logic                          s_axis_tlast,   // last_in
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [55:0]                   m_axis_tdata,   // out_value, dest_index
  output logic                          m_axis_tlast,   // last_out
  output logic                          m_axis_tuser    // size_error
);
  import tlp_pkg::*;

  cfg_t         cfg_q;
  stride_t      stride;
  logic [SettleW-1:0] settle_q;
  logic         cfg_hit;
  logic         in_acc;

  logic [5:0]   pos_outer_q, pos_outer_d;
  logic [11:0]  pos_chan_q, pos_chan_d;
  logic [9:0]   pos_row_q, pos_row_d;
  logic [9:0]   pos_col_q, pos_col_d;
  logic [DestW-1:0] term_outer_q, term_outer_d;
  logic [DestW-1:0] term_chan_q, term_chan_d;
  logic [DestW-1:0] term_row_q, term_row_d;
  logic [DestW-1:0] term_col_q, term_col_d;

  logic [10:0]  w_eff;
  logic         fin;
  logic         wrap_outer, wrap_chan, wrap_row, wrap_col;
  logic [DestW-1:0] dest_sum;

  logic         out_valid_q;
  logic [ValueW-1:0] out_value_q;
  logic [DestW-1:0]  out_dest_q;
  logic         out_last_q;
  logic         out_err_q;

  tlp_stride u_stride (
    .clk_i    (clk_i),
    .cfg_i    (cfg_q),
    .stride_o (stride)
  );

  assign cfg_hit = cfg_we_i && (cfg_idx_i == REG_MODE || cfg_idx_i == REG_OUTER ||
                                cfg_idx_i == REG_CHANNEL || cfg_idx_i == REG_HEIGHT ||
                                cfg_idx_i == REG_WIDTH);

  assign s_axis_tready = (settle_q == '0) && (!out_valid_q || m_axis_tready);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign w_eff = (cfg_q.mode == MODE_OIKK_IOKK) ? cfg_q.height : cfg_q.width;

  assign fin = ({1'b0, pos_outer_q} == cfg_q.outer_count - 7'd1) &&
               ({1'b0, pos_chan_q} == cfg_q.channel_count - 13'd1) &&
               ({1'b0, pos_row_q} == cfg_q.height - 11'd1) &&
               ({1'b0, pos_col_q} == w_eff - 11'd1);

  assign wrap_outer = ({1'b0, pos_outer_q} + 7'd1) >= cfg_q.outer_count;
  assign wrap_chan  = ({1'b0, pos_chan_q} + 13'd1) >= cfg_q.channel_count;
  assign wrap_row   = ({1'b0, pos_row_q} + 11'd1) >= cfg_q.height;
  assign wrap_col   = ({1'b0, pos_col_q} + 11'd1) >= w_eff;

  assign dest_sum = term_outer_q + term_chan_q + term_row_q + term_col_q;

  // position counters and per-axis index terms
  always_comb begin
    pos_outer_d  = pos_outer_q;
    pos_chan_d   = pos_chan_q;
    pos_row_d    = pos_row_q;
    pos_col_d    = pos_col_q;
    term_outer_d = term_outer_q;
    term_chan_d  = term_chan_q;
    term_row_d   = term_row_q;
    term_col_d   = term_col_q;
    if (in_acc) begin
      if (!stride.ok || fin || s_axis_tlast) begin
        pos_outer_d  = '0;
        pos_chan_d   = '0;
        pos_row_d    = '0;
        pos_col_d    = '0;
        term_outer_d = '0;
        term_chan_d  = '0;
        term_row_d   = '0;
        term_col_d   = '0;
      end else if (cfg_q.mode == MODE_NHWC_NCHW) begin
        pos_chan_d  = pos_chan_q + 12'd1;
        term_chan_d = term_chan_q + stride.s_chan;
        if (wrap_chan) begin
          pos_chan_d  = '0;
          term_chan_d = '0;
          pos_col_d   = pos_col_q + 10'd1;
          term_col_d  = term_col_q + stride.s_col;
          if (wrap_col) begin
            pos_col_d  = '0;
            term_col_d = '0;
            pos_row_d  = pos_row_q + 10'd1;
            term_row_d = term_row_q + stride.s_row;
            if (wrap_row) begin
              pos_row_d    = '0;
              term_row_d   = '0;
              pos_outer_d  = pos_outer_q + 6'd1;
              term_outer_d = term_outer_q + stride.s_outer;
              if (wrap_outer) begin
                pos_outer_d  = '0;
                term_outer_d = '0;
              end
            end
          end
        end
      end else begin
        pos_col_d  = pos_col_q + 10'd1;
        term_col_d = term_col_q + stride.s_col;
        if (wrap_col) begin
          pos_col_d  = '0;
          term_col_d = '0;
          pos_row_d  = pos_row_q + 10'd1;
          term_row_d = term_row_q + stride.s_row;
          if (wrap_row) begin
            pos_row_d   = '0;
            term_row_d  = '0;
            pos_chan_d  = pos_chan_q + 12'd1;
            term_chan_d = term_chan_q + stride.s_chan;
            if (wrap_chan) begin
              pos_chan_d   = '0;
              term_chan_d  = '0;
              pos_outer_d  = pos_outer_q + 6'd1;
              term_outer_d = term_outer_q + stride.s_outer;
              if (wrap_outer) begin
                pos_outer_d  = '0;
                term_outer_d = '0;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode          <= MODE_NCHW_NHWC;
      cfg_q.outer_count   <= 7'd1;
      cfg_q.channel_count <= 13'd1;
      cfg_q.height        <= 11'd1;
      cfg_q.width         <= 11'd1;
      settle_q            <= SettleW'(SettleCycles);
      pos_outer_q         <= '0;
      pos_chan_q          <= '0;
      pos_row_q           <= '0;
      pos_col_q           <= '0;
      term_outer_q        <= '0;
      term_chan_q         <= '0;
      term_row_q          <= '0;
      term_col_q          <= '0;
      out_valid_q         <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MODE:    cfg_q.mode          <= cfg_data_i[1:0];
          REG_OUTER:   cfg_q.outer_count   <= cfg_data_i[6:0];
          REG_CHANNEL: cfg_q.channel_count <= cfg_data_i[12:0];
          REG_HEIGHT:  cfg_q.height        <= cfg_data_i[10:0];
          REG_WIDTH:   cfg_q.width         <= cfg_data_i[10:0];
          default: ;
        endcase
      end
      if (cfg_hit) begin
        settle_q     <= SettleW'(SettleCycles);
        pos_outer_q  <= '0;
        pos_chan_q   <= '0;
        pos_row_q    <= '0;
        pos_col_q    <= '0;
        term_outer_q <= '0;
        term_chan_q  <= '0;
        term_row_q   <= '0;
        term_col_q   <= '0;
      end else begin
        if (settle_q != '0) begin
          settle_q <= settle_q - SettleW'(1);
        end
        pos_outer_q  <= pos_outer_d;
        pos_chan_q   <= pos_chan_d;
        pos_row_q    <= pos_row_d;
        pos_col_q    <= pos_col_d;
        term_outer_q <= term_outer_d;
        term_chan_q  <= term_chan_d;
        term_row_q   <= term_row_d;
        term_col_q   <= term_col_d;
      end
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_value_q <= s_axis_tdata;
      out_dest_q  <= stride.ok ? dest_sum : '0;
      out_last_q  <= stride.ok && fin && s_axis_tlast;
      out_err_q   <= !stride.ok || (fin != s_axis_tlast);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_dest_q, out_value_q};
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_err_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_hit |=> !s_axis_tready)
    else $error("input taken while stride pipeline settles");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tlast && m_axis_tuser))
    else $error("result flagged both complete and size error");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !stride.ok && !cfg_hit) |=>
      (pos_outer_q == '0 && pos_chan_q == '0 && pos_row_q == '0 && pos_col_q == '0 &&
       dest_sum == '0))
    else $error("counters not cleared under invalid settings");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while result register is held");
`endif

endmodule
